FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_AT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a rising clk edge outside reset.
`define ASSERT_NEVER_AT_CLK(label, cond, msg) \
  `ASSERT_AT_CLK(label, !(cond), msg)

`endif

FILE: hdl/smii_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smii_pkg
// Shared constants, types and register indexes of the skin mask integral
// image unit.
// ----------------------------------------------------------------------------
package smii_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;

  localparam int PIX_W       = 8;
  localparam int CFG_W       = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int INTEGRAL_W  = 19;

  localparam int COL_W = $clog2(FRAME_WIDTH);
  localparam int ROW_W = $clog2(FRAME_HEIGHT);
  // Skin count within one row never exceeds FRAME_WIDTH - 1.
  localparam int CNT_W = COL_W;

  localparam logic [CFG_W-1:0] RED_MIN_RESET    = 8'd95;
  localparam logic [CFG_W-1:0] GREEN_MIN_RESET  = 8'd40;
  localparam logic [CFG_W-1:0] BLUE_MIN_RESET   = 8'd20;
  localparam logic [CFG_W-1:0] RED_MARGIN_RESET = 8'd15;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RED_MIN    = 3'd0,
    REG_GREEN_MIN  = 3'd1,
    REG_BLUE_MIN   = 3'd2,
    REG_RED_MARGIN = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] red_min;
    logic [CFG_W-1:0] green_min;
    logic [CFG_W-1:0] blue_min;
    logic [CFG_W-1:0] red_margin;
  } thresh_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             col_zero;
    logic             row_zero;
    logic             last;
  } pos_t;

endpackage

FILE: hdl/smii_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smii_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module smii_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/smii_frame_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smii_frame_counter
// Column and row position of the next pixel in raster order, with border
// and end-of-frame flags.
// ----------------------------------------------------------------------------
module smii_frame_counter (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  output smii_pkg::pos_t    pos
);

  logic [smii_pkg::COL_W-1:0] col;
  logic [smii_pkg::ROW_W-1:0] row;
  logic                       col_last;
  logic                       row_last;

  assign col_last = (col == smii_pkg::COL_W'(smii_pkg::FRAME_WIDTH - 1));
  assign row_last = (row == smii_pkg::ROW_W'(smii_pkg::FRAME_HEIGHT - 1));

  assign pos.col      = col;
  assign pos.col_zero = (col == '0);
  assign pos.row_zero = (row == '0);
  assign pos.last     = col_last && row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (col_last) begin
        col <= '0;
        // wrap to the top after the last row
        row <= row_last ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

FILE: hdl/smii_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smii_classifier
// RGB skin color rule: thresholds per channel and red dominance by a margin.
// ----------------------------------------------------------------------------
module smii_classifier (
  input  smii_pkg::thresh_t           thr,
  input  logic [smii_pkg::PIX_W-1:0]  red,
  input  logic [smii_pkg::PIX_W-1:0]  green,
  input  logic [smii_pkg::PIX_W-1:0]  blue,
  output logic                        skin
);

  logic [smii_pkg::PIX_W-1:0] low_gb;
  logic [smii_pkg::PIX_W:0]   green_plus;
  logic [smii_pkg::PIX_W:0]   low_plus;
  logic [smii_pkg::PIX_W:0]   red_ext;

  assign low_gb     = (green < blue) ? green : blue;
  // one extra bit so the margin sum cannot wrap
  assign green_plus = {1'b0, green} + {1'b0, thr.red_margin};
  assign low_plus   = {1'b0, low_gb} + {1'b0, thr.red_margin};
  assign red_ext    = {1'b0, red};

  assign skin = (red > thr.red_min) && (green > thr.green_min) &&
                (blue > thr.blue_min) && (red > green) && (red > blue) &&
                (red_ext > green_plus) && (red_ext > low_plus);

endmodule

FILE: hdl/skin_mask_integral_image_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_mask_integral_image_unit
// Skin color mask and running integral image over a raster pixel stream.
// ----------------------------------------------------------------------------
//   Pixels enter on in_valid / in_stall as pixel_red, pixel_green and
//   pixel_blue in raster order; the unit counts column and row itself.
//   Every request yields one result on out_valid / out_stall: skin_flag,
//   integral_value and frame_end (set on the last pixel of the frame).
//   An accepted request passes the input register, then the result register,
//   where out_valid rises. Throughput is one pixel per cycle while out_stall
//   is low, set by the line buffer RAM (one read at accept, one write as the
//   pixel leaves the compute stage) and one 19 bit add.
//   While out_stall is high the result register holds; the compute stage
//   still takes one more request, then in_stall rises until the result is
//   taken. Reset clears the position, the row count, the pipeline valids
//   and loads the default thresholds. The line buffer needs no clearing:
//   row 0 writes every entry but column 0 before row 1 reads it, and column 0
//   never uses the read. Threshold registers are written through cfg_wr_en,
//   cfg_index and cfg_data; indexes outside the register list are ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skin_mask_integral_image_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [smii_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [smii_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [smii_pkg::PIX_W-1:0]          pixel_red,
  input  logic [smii_pkg::PIX_W-1:0]          pixel_green,
  input  logic [smii_pkg::PIX_W-1:0]          pixel_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                skin_flag,
  output logic [smii_pkg::INTEGRAL_W-1:0]     integral_value,
  output logic                                frame_end
);

  smii_pkg::thresh_t               thr;
  smii_pkg::pos_t                  pos;
  logic                            in_accept;
  logic                            out_load;
  logic                            s1_adv;

  logic                            s1_valid;
  smii_pkg::pos_t                  s1_pos;
  logic [smii_pkg::PIX_W-1:0]      s1_red;
  logic [smii_pkg::PIX_W-1:0]      s1_green;
  logic [smii_pkg::PIX_W-1:0]      s1_blue;

  logic [smii_pkg::CNT_W-1:0]      row_count;
  logic [smii_pkg::CNT_W-1:0]      row_count_next;
  logic [smii_pkg::INTEGRAL_W-1:0] above;
  logic                            skin_raw;
  logic                            s1_skin;
  logic [smii_pkg::INTEGRAL_W-1:0] s1_value;

  // Handshake
  assign out_load  = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && out_load;
  assign in_stall  = s1_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.red_min    <= smii_pkg::RED_MIN_RESET;
      thr.green_min  <= smii_pkg::GREEN_MIN_RESET;
      thr.blue_min   <= smii_pkg::BLUE_MIN_RESET;
      thr.red_margin <= smii_pkg::RED_MARGIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        smii_pkg::REG_RED_MIN:    thr.red_min    <= cfg_data;
        smii_pkg::REG_GREEN_MIN:  thr.green_min  <= cfg_data;
        smii_pkg::REG_BLUE_MIN:   thr.blue_min   <= cfg_data;
        smii_pkg::REG_RED_MARGIN: thr.red_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  smii_frame_counter u_frame_counter (
    .clk     (clk),
    .rst     (rst),
    .advance (in_accept),
    .pos     (pos)
  );

  // Line buffer: integral values of the row above
  smii_ram #(
    .WIDTH (smii_pkg::INTEGRAL_W),
    .DEPTH (smii_pkg::FRAME_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv && !s1_pos.col_zero),
    .wr_addr (s1_pos.col),
    .wr_data (s1_value),
    .rd_en   (in_accept),
    .rd_addr (pos.col),
    .rd_data (above)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos   <= pos;
      s1_red   <= pixel_red;
      s1_green <= pixel_green;
      s1_blue  <= pixel_blue;
    end
  end

  smii_classifier u_classifier (
    .thr   (thr),
    .red   (s1_red),
    .green (s1_green),
    .blue  (s1_blue),
    .skin  (skin_raw)
  );

  // Compute stage
  always_comb begin
    s1_skin        = skin_raw && !s1_pos.col_zero && !s1_pos.row_zero;
    row_count_next = row_count + smii_pkg::CNT_W'(s1_skin);
    priority if (s1_pos.col_zero) begin
      s1_value = smii_pkg::INTEGRAL_W'(1);
    end else if (s1_pos.row_zero) begin
      s1_value = '0;
    end else begin
      s1_value = above + smii_pkg::INTEGRAL_W'(row_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
    end else if (s1_adv) begin
      // restart the count at the start of each row
      row_count <= s1_pos.col_zero ? '0 : row_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      skin_flag      <= s1_skin;
      integral_value <= s1_value;
      frame_end      <= s1_pos.last;
    end
  end

  // Assertions
  `ASSERT_AT_CLK(a_wrap_after_last,
                 (in_accept && pos.last) |=> (pos.col_zero && pos.row_zero),
                 "position did not wrap after the last pixel")
  `ASSERT_NEVER_AT_CLK(a_stall_needs_busy,
                       in_stall && !s1_valid,
                       "input stalled with an empty compute stage")
  `ASSERT_AT_CLK(a_accept_fills_stage,
                 in_accept |=> s1_valid,
                 "accepted request did not reach the compute stage")
  `ASSERT_AT_CLK(a_count_restart,
                 (s1_adv && s1_pos.col_zero) |=> (row_count == '0),
                 "row count not cleared at column zero")

endmodule

FILE: test/tb_skin_mask_integral_image_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_skin_mask_integral_image_unit
// Streams pixels through the skin mask integral image unit and compares every
// result with an in-bench classifier and running integral sum. Covers rule
// edges, threshold extremes, ignored register writes, random bursts with
// receiver stalls, and a run with no sender gaps across a row boundary.
// ----------------------------------------------------------------------------
module tb_skin_mask_integral_image_unit;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PRINT_LIMIT    = 40;

  typedef logic [smii_pkg::PIX_W-1:0] chan_t;

  typedef struct {
    logic                            skin;
    logic [smii_pkg::INTEGRAL_W-1:0] integral;
    logic                            frame_last;
  } pixel_result_t;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cfg_wr_en = 1'b0;
  logic [smii_pkg::CFG_INDEX_W-1:0] cfg_index = smii_pkg::REG_RED_MIN;
  logic [smii_pkg::CFG_W-1:0]       cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  chan_t                            pixel_red = '0;
  chan_t                            pixel_green = '0;
  chan_t                            pixel_blue = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             skin_flag;
  logic [smii_pkg::INTEGRAL_W-1:0]  integral_value;
  logic                             frame_end;

  skin_mask_integral_image_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel_red      (pixel_red),
    .pixel_green    (pixel_green),
    .pixel_blue     (pixel_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .skin_flag      (skin_flag),
    .integral_value (integral_value),
    .frame_end      (frame_end)
  );

  // Classifier state mirrored in the bench
  smii_pkg::thresh_t               cur_thresh;
  logic [smii_pkg::INTEGRAL_W-1:0] above_row [smii_pkg::FRAME_WIDTH];
  logic [smii_pkg::CNT_W-1:0]      row_skin_count;
  int                              pred_col;
  int                              pred_row;
  pixel_result_t                   pending_results [$];

  int errors = 0;
  int results_checked = 0;
  int skin_seen = 0;
  int frames_ended = 0;
  int settings_used = 0;
  int pixels_sent = 0;
  int burst_left = 0;
  bit sender_gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic pixel_is_skin(input chan_t r, input chan_t g, input chan_t b);
    int ri;
    int gi;
    int bi;
    int lo;
    ri = r;
    gi = g;
    bi = b;
    lo = (gi < bi) ? gi : bi;
    return ri > int'(cur_thresh.red_min) && gi > int'(cur_thresh.green_min) &&
           bi > int'(cur_thresh.blue_min) && ri > gi && ri > bi &&
           ri > gi + int'(cur_thresh.red_margin) &&
           ri > lo + int'(cur_thresh.red_margin);
  endfunction

  // Advance the position and integral sum for one accepted request.
  task automatic predict_pixel(input chan_t r, input chan_t g, input chan_t b);
    pixel_result_t res;
    res.skin = 1'b0;
    if (pred_col == 0) begin
      row_skin_count = '0;
      res.integral = smii_pkg::INTEGRAL_W'(1);
    end else if (pred_row == 0) begin
      res.integral = '0;
      above_row[pred_col] = '0;
    end else begin
      res.skin = pixel_is_skin(r, g, b);
      row_skin_count = row_skin_count + smii_pkg::CNT_W'(res.skin);
      res.integral = above_row[pred_col] + smii_pkg::INTEGRAL_W'(row_skin_count);
      above_row[pred_col] = res.integral;
    end
    res.frame_last = (pred_row == smii_pkg::FRAME_HEIGHT - 1) &&
                     (pred_col == smii_pkg::FRAME_WIDTH - 1);
    if (pred_col + 1 >= smii_pkg::FRAME_WIDTH) begin
      pred_col = 0;
      pred_row = (pred_row + 1 >= smii_pkg::FRAME_HEIGHT) ? 0 : pred_row + 1;
    end else begin
      pred_col = pred_col + 1;
    end
    pending_results.insert(pending_results.size(), res);
  endtask

  task automatic check_result();
    pixel_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: skin=%0b integral=%0d end=%0b",
                                skin_flag, integral_value, frame_end));
    end else begin
      want = pending_results.pop_front();
      if (skin_flag !== want.skin)
        report_mismatch($sformatf("skin_flag %0b, want %0b", skin_flag, want.skin));
      if (integral_value !== want.integral)
        report_mismatch($sformatf("integral_value %0d, want %0d",
                                  integral_value, want.integral));
      if (frame_end !== want.frame_last)
        report_mismatch($sformatf("frame_end %0b, want %0b", frame_end, want.frame_last));
      results_checked++;
      if (want.skin) skin_seen++;
      if (want.frame_last) frames_ended++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_pixel(pixel_red, pixel_green, pixel_blue);
    if (!rst && out_valid && !out_stall) check_result();
  end

  // Receiver stall pattern: switch to a random mode when the timer runs out.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_timer = 0;
  int          stall_phase = 0;

  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
      stall_timer <= $urandom_range(50, 400);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    stall_phase <= (stall_phase + 1) % 7;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_SPARSE:   out_stall <= ($urandom_range(0, 5) == 0);
      STALL_PERIODIC: out_stall <= (stall_phase < 3);
      default:        out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one request; open a new burst with a random gap when the last one ran out.
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    int gap;
    if (sender_gaps_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    pixel_red   <= r;
    pixel_green <= g;
    pixel_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Hold the sender until every pending result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [smii_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [smii_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      smii_pkg::REG_RED_MIN:    cur_thresh.red_min    = val;
      smii_pkg::REG_GREEN_MIN:  cur_thresh.green_min  = val;
      smii_pkg::REG_BLUE_MIN:   cur_thresh.blue_min   = val;
      smii_pkg::REG_RED_MARGIN: cur_thresh.red_margin = val;
      default: ;
    endcase
  endtask

  task automatic program_thresholds(input smii_pkg::thresh_t t);
    wait_drained();
    cfg_write(smii_pkg::REG_RED_MIN, t.red_min);
    cfg_write(smii_pkg::REG_GREEN_MIN, t.green_min);
    cfg_write(smii_pkg::REG_BLUE_MIN, t.blue_min);
    cfg_write(smii_pkg::REG_RED_MARGIN, t.red_margin);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic chan_t clip_chan(input int v);
    return (v > 255) ? chan_t'(255) : (v < 0) ? chan_t'(0) : chan_t'(v);
  endfunction

  task automatic random_pixel(output chan_t r, output chan_t g, output chan_t b);
    int gi;
    int bi;
    case ($urandom_range(0, 3))
      0: begin  // skin-like: red dominant
        gi = $urandom_range(0, 200);
        bi = $urandom_range(0, gi);
        g = chan_t'(gi);
        b = chan_t'(bi);
        r = clip_chan(int'($urandom_range(gi, 255)));
      end
      1: begin  // straddle the thresholds
        g = clip_chan(int'(cur_thresh.green_min) + int'($urandom_range(0, 2)));
        b = clip_chan(int'(cur_thresh.blue_min) + int'($urandom_range(0, 2)));
        gi = (g > b) ? g : b;
        r = clip_chan(gi + int'(cur_thresh.red_margin) + int'($urandom_range(0, 2)));
      end
      default: begin
        r = chan_t'($urandom_range(0, 255));
        g = chan_t'($urandom_range(0, 255));
        b = chan_t'($urandom_range(0, 255));
      end
    endcase
  endtask

  task automatic send_random(input int count);
    chan_t r;
    chan_t g;
    chan_t b;
    repeat (count) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Row 0 is never classified, the corner reads 1; extremes go through here too.
  task automatic test_first_row();
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h64, 8'h32);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_random(smii_pkg::FRAME_WIDTH - 4);
  endtask

  // Row 1 at default thresholds: column 0 first, then each rule at its edge.
  task automatic test_rule_edges();
    send_pixel(8'hFF, 8'h64, 8'h32);
    send_pixel(8'd96, 8'd41, 8'd21);
    send_pixel(8'd95, 8'd41, 8'd21);
    send_pixel(8'd96, 8'd40, 8'd21);
    send_pixel(8'd96, 8'd41, 8'd20);
    send_pixel(8'd200, 8'd200, 8'd50);
    send_pixel(8'd200, 8'd50, 8'd200);
    send_pixel(8'd115, 8'd100, 8'd50);
    send_pixel(8'd116, 8'd100, 8'd50);
    send_pixel(8'd116, 8'd50, 8'd100);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'd41, 8'd21);
    send_pixel(8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_threshold_extremes();
    program_thresholds('{red_min: 8'h00, green_min: 8'h00, blue_min: 8'h00,
                         red_margin: 8'h00});
    send_pixel(8'd3, 8'd1, 8'd1);
    send_pixel(8'd2, 8'd1, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd0);
    program_thresholds('{red_min: 8'hFF, green_min: 8'hFF, blue_min: 8'hFF,
                         red_margin: 8'hFF});
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFE, 8'hFE);
    // red_margin large enough that green + margin overflows eight bits
    program_thresholds('{red_min: 8'h00, green_min: 8'h00, blue_min: 8'h00,
                         red_margin: 8'd200});
    send_pixel(8'd255, 8'd100, 8'd10);
    send_pixel(8'd251, 8'd50, 8'd10);
    send_pixel(8'd250, 8'd50, 8'd10);
    program_thresholds('{red_min: smii_pkg::RED_MIN_RESET,
                         green_min: smii_pkg::GREEN_MIN_RESET,
                         blue_min: smii_pkg::BLUE_MIN_RESET,
                         red_margin: smii_pkg::RED_MARGIN_RESET});
  endtask

  // Writes beyond the last register must leave the thresholds alone.
  task automatic test_ignored_index();
    wait_drained();
    for (int i = smii_pkg::REG_RED_MARGIN + 1; i < (1 << smii_pkg::CFG_INDEX_W); i++)
      cfg_write(smii_pkg::CFG_INDEX_W'(i), 8'h00);
    cfg_wr_en <= 1'b0;
    send_pixel(8'd50, 8'd45, 8'd25);
    send_pixel(8'd60, 8'd41, 8'd21);
    send_random(20);
  endtask

  task automatic test_random_stream();
    smii_pkg::thresh_t t;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: t = '{red_min: 8'h00, green_min: 8'h00, blue_min: 8'h00, red_margin: 8'h00};
        3: t = '{red_min: 8'hFF, green_min: 8'hFF, blue_min: 8'hFF, red_margin: 8'hFF};
        default: t = '{red_min: smii_pkg::CFG_W'($urandom_range(0, 200)),
                       green_min: smii_pkg::CFG_W'($urandom_range(0, 150)),
                       blue_min: smii_pkg::CFG_W'($urandom_range(0, 120)),
                       red_margin: smii_pkg::CFG_W'($urandom_range(0, 60))};
      endcase
      program_thresholds(t);
      send_random(120);
      if (phase == 2) wait_drained();
      send_random(120);
    end
    program_thresholds('{red_min: smii_pkg::RED_MIN_RESET,
                         green_min: smii_pkg::GREEN_MIN_RESET,
                         blue_min: smii_pkg::BLUE_MIN_RESET,
                         red_margin: smii_pkg::RED_MARGIN_RESET});
  endtask

  // Stream back to back with no sender gaps, then restore the bursts.
  task automatic test_no_gaps();
    sender_gaps_on = 1'b0;
    send_random(smii_pkg::FRAME_WIDTH / 4);
    sender_gaps_on = 1'b1;
    burst_left = 0;
  endtask

  initial begin
    int waited;
    cur_thresh = '{red_min: smii_pkg::RED_MIN_RESET, green_min: smii_pkg::GREEN_MIN_RESET,
                   blue_min: smii_pkg::BLUE_MIN_RESET,
                   red_margin: smii_pkg::RED_MARGIN_RESET};
    foreach (above_row[i]) above_row[i] = '0;
    row_skin_count = '0;
    pred_col = 0;
    pred_row = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_first_row();
    test_rule_edges();
    test_threshold_extremes();
    test_ignored_index();
    test_random_stream();
    test_no_gaps();

    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < WATCHDOG_LIMIT / 2) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    repeat (8) @(posedge clk);

    $display("Checked %0d results from %0d pixels: %0d skin, %0d frame ends",
             results_checked, pixels_sent, skin_seen, frames_ended);
    $display("Threshold settings programmed: %0d, mismatches: %0d", settings_used, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
